### rtl/kf_pkg.sv
// Shared types, constants and the microcode table of the scalar Kalman filter.
package kf_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned AddrW         = 4;
  localparam int unsigned DivSteps      = 32;
  localparam int unsigned CntW          = $clog2(DivSteps);

  localparam logic [31:0] ProcessNoiseRst = 32'd300648;
  localparam logic [31:0] MeasureNoiseRst = 32'd1288490;
  localparam logic [31:0] InitialCovRst   = 32'd85899346;

  typedef enum logic [1:0] {
    RegProcessNoise = 2'd0,
    RegMeasureNoise = 2'd1,
    RegInitialCov   = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    UopIdle,
    UopPred,
    UopDiv,
    UopGain,
    UopMulLo,
    UopMulHi,
    UopCorr,
    UopCov,
    UopRestart
  } uop_e;

  typedef enum logic [1:0] {
    JmpNext,
    JmpLoop,
    JmpAlways,
    JmpRestart
  } jmp_e;

  typedef enum logic {
    MulCorr,
    MulCov
  } mul_sel_e;

  localparam int unsigned PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PcIdle    = 4'd0;
  localparam pc_t PcDiv     = 4'd2;
  localparam pc_t PcRestart = 4'd10;

  typedef struct packed {
    uop_e     uop;
    mul_sel_e msel;
    logic     emit;
    jmp_e     jmp;
    pc_t      target;
  } ucode_t;

  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t uc;
    uc = '{uop: UopIdle, msel: MulCorr, emit: 1'b0, jmp: JmpNext, target: PcIdle};
    case (pc)
      4'd0: begin
        uc.jmp    = JmpRestart;
        uc.target = PcRestart;
      end
      4'd1: uc.uop = UopPred;
      4'd2: begin
        uc.uop    = UopDiv;
        uc.jmp    = JmpLoop;
        uc.target = PcDiv;
      end
      4'd3: uc.uop = UopGain;
      4'd4: uc.uop = UopMulLo;
      4'd5: uc.uop = UopMulHi;
      4'd6: uc.uop = UopCorr;
      4'd7: begin
        uc.uop  = UopMulLo;
        uc.msel = MulCov;
      end
      4'd8: begin
        uc.uop  = UopMulHi;
        uc.msel = MulCov;
      end
      4'd9: begin
        uc.uop  = UopCov;
        uc.emit = 1'b1;
        uc.jmp  = JmpAlways;
      end
      4'd10: begin
        uc.uop  = UopRestart;
        uc.emit = 1'b1;
        uc.jmp  = JmpAlways;
      end
      default: uc.jmp = JmpAlways;
    endcase
    return uc;
  endfunction

endpackage

### rtl/kf_if.sv
// Valid/ready channel interfaces for the filter's input and result items.
interface kf_in_if #(
  parameter int unsigned SAMPLE_BITS = kf_pkg::SampleBitsDef
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, op, sample, input ready);
  modport sink   (input valid, op, sample, output ready);
endinterface

interface kf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] estimate;
  logic        [31:0] gain;

  modport source (output valid, estimate, gain, input ready);
  modport sink   (input valid, estimate, gain, output ready);
endinterface

### rtl/scalar_kalman_filter.sv
// Scalar Kalman filter: microcoded sequencer over a divide/multiply datapath.
//
//   channel  dir  handshake            payload
//   in_i     in   valid/ready          op, sample
//   out_o    out  valid/ready          estimate, gain
//   apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// A filter item is finished before the next item can be taken: the gain comes from a
// bit-serial restoring divide, and the two 33x32 products are each done as two 33x16
// halves. A restart item reloads the state and emits a zero result.
// Reset clears the estimate and loads the covariance and registers with defaults.
// A held result stalls only the final step; the item is otherwise left in the output register.
module scalar_kalman_filter #(
  parameter int unsigned SAMPLE_BITS = kf_pkg::SampleBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kf_in_if.sink                    in_i,
  kf_out_if.source                 out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [kf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import kf_pkg::*;

  localparam int unsigned WideW = (SAMPLE_BITS + 16 > 33) ? SAMPLE_BITS + 16 : 33;

  // Configuration registers
  logic [31:0] q_noise_q, r_noise_q, init_cov_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q  <= ProcessNoiseRst;
      r_noise_q  <= MeasureNoiseRst;
      init_cov_q <= InitialCovRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegProcessNoise: q_noise_q  <= pwdata;
        RegMeasureNoise: r_noise_q  <= pwdata;
        RegInitialCov:   init_cov_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegProcessNoise: prdata = q_noise_q;
      RegMeasureNoise: prdata = r_noise_q;
      RegInitialCov:   prdata = init_cov_q;
      default:         prdata = '0;
    endcase
  end

  // Sequencer
  pc_t            pc_q, pc_d, pc_jump;
  logic [CntW-1:0] cnt_q, cnt_d;
  ucode_t         uc;
  logic           accept, stall, advance;
  logic           out_valid_q, out_valid_d;

  assign uc      = ucode_rom(pc_q);
  assign accept  = in_i.valid && in_i.ready;
  assign stall   = uc.emit && out_valid_q && !out_o.ready;
  assign advance = (uc.uop == UopIdle) ? accept : !stall;
  assign in_i.ready = (uc.uop == UopIdle);

  always_comb begin
    case (uc.jmp)
      JmpNext:    pc_jump = pc_t'(pc_q + 1'b1);
      JmpLoop:    pc_jump = (cnt_q != '0) ? uc.target : pc_t'(pc_q + 1'b1);
      JmpAlways:  pc_jump = uc.target;
      JmpRestart: pc_jump = in_i.op ? uc.target : pc_t'(pc_q + 1'b1);
      default:    pc_jump = PcIdle;
    endcase
    pc_d = advance ? pc_jump : pc_q;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (uc.uop == UopPred) begin
      cnt_d = CntW'(DivSteps - 1);
    end else if (uc.uop == UopDiv) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Datapath
  logic [31:0] target_q, target_d;
  logic [31:0] est_q, est_d;
  logic [31:0] cov_q, cov_d;
  logic [31:0] pred_q, pred_d;
  logic [32:0] denom_q, denom_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] gain_q, gain_d;
  logic [32:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [64:0] acc_q, acc_d;

  logic [WideW-1:0] wide;
  logic             sat_hi, sat_lo;
  logic [32:0]      cov_sum, pred_sum;
  logic [31:0]      pred_sat;
  logic [33:0]      rem2;
  logic             rem_ge;
  logic [32:0]      diff;
  logic [32:0]      mul_a;
  logic [31:0]      mul_b;
  logic [15:0]      mul_b_half;
  logic [48:0]      prod;
  logic [32:0]      est_next;

  // The sample scaled to Q16.16, saturated to 32 bits when the sample is wide.
  assign wide   = WideW'($signed({in_i.sample, 16'h0000}));
  assign sat_hi = !wide[WideW-1] && (|wide[WideW-2:31]);
  assign sat_lo = wide[WideW-1] && !(&wide[WideW-2:31]);

  assign cov_sum  = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign pred_sat = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
  assign pred_sum = {1'b0, pred_sat} + {1'b0, r_noise_q};
  assign rem2     = {rem_q, 1'b0};
  assign rem_ge   = rem2 >= {1'b0, denom_q};
  assign diff     = {target_q[31], target_q} - {est_q[31], est_q};

  assign mul_a      = (uc.msel == MulCorr) ? mag_q : (33'h1_0000_0000 - {1'b0, gain_q});
  assign mul_b      = (uc.msel == MulCorr) ? gain_q : pred_q;
  assign mul_b_half = (uc.uop == UopMulLo) ? mul_b[15:0] : mul_b[31:16];
  assign prod       = {16'h0000, mul_a} * {33'h0, mul_b_half};

  // The correction never exceeds the distance to the target, so 32 bits hold the sum.
  assign est_next = neg_q ? ({est_q[31], est_q} - acc_q[64:32])
                          : ({est_q[31], est_q} + acc_q[64:32]);

  always_comb begin
    target_d = target_q;
    est_d    = est_q;
    cov_d    = cov_q;
    pred_d   = pred_q;
    denom_d  = denom_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    gain_d   = gain_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    case (uc.uop)
      UopIdle: begin
        if (accept) begin
          target_d = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : wide[31:0]);
        end
      end
      UopPred: begin
        pred_d  = pred_sat;
        denom_d = pred_sum;
        rem_d   = {1'b0, pred_sat};
      end
      UopDiv: begin
        rem_d = rem_ge ? 33'(rem2 - {1'b0, denom_q}) : rem2[32:0];
        quo_d = {quo_q[30:0], rem_ge};
      end
      UopGain: begin
        // With no prediction and no noise the divider sees a zero divisor.
        gain_d = (pred_q == '0) ? '0 : quo_q;
        neg_d  = diff[32];
        mag_d  = diff[32] ? (~diff + 33'd1) : diff;
      end
      UopMulLo: acc_d = {16'h0000, prod};
      UopMulHi: acc_d = acc_q + {prod, 16'h0000};
      UopCorr:  est_d = est_next[31:0];
      UopCov:   cov_d = acc_q[63:32];
      UopRestart: begin
        est_d  = '0;
        cov_d  = init_cov_q;
        gain_d = '0;
      end
      default: ;
    endcase
  end

  // Output register
  logic signed [15:0] out_est_q, out_est_d;
  logic        [31:0] out_gain_q, out_gain_d;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_est_d   = out_est_q;
    out_gain_d  = out_gain_q;
    if (uc.emit && !stall) begin
      out_valid_d = 1'b1;
      out_est_d   = (uc.uop == UopRestart) ? '0 : est_q[31:16];
      out_gain_d  = (uc.uop == UopRestart) ? '0 : gain_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.estimate = out_est_q;
  assign out_o.gain     = out_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      est_q       <= '0;
      cov_q       <= InitialCovRst;
    end else begin
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      est_q       <= est_d;
      cov_q       <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    pred_q     <= pred_d;
    denom_q    <= denom_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    gain_q     <= gain_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    acc_q      <= acc_d;
    out_est_q  <= out_est_d;
    out_gain_q <= out_gain_d;
  end

endmodule

### rtl/kf_check.sv
// Port-level checker for the scalar Kalman filter, bound to the top level.
module kf_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_estimate_i,
  input logic [31:0] out_gain_i
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still ready right after an item was accepted");

  // A new result appears exactly when the sequencer goes back to waiting.
  a_result_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $rose(in_ready_i))
    else $error("result appeared while the block was not finishing an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_estimate_i) && $stable(out_gain_i))
    else $error("stalled result changed or dropped");

endmodule

bind scalar_kalman_filter kf_check u_kf_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_estimate_i (out_o.estimate),
  .out_gain_i     (out_o.gain)
);

### tb/kf_tb_pkg.sv
// Testbench-side codes for the checker and the stimulus, and the result item type of the checker.
`timescale 1ns / 1ps
package kf_tb_pkg;

  localparam logic OpFilter  = 1'b0;
  localparam logic OpRestart = 1'b1;

  // No register lives at this index; writes to it must leave every register alone.
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic signed [15:0] estimate;
    logic        [31:0] gain;
  } kf_result_t;

endpackage

### tb/kf_checker.sv
// Watches the sample, result and register ports, predicts each result and compares it.
`timescale 1ns / 1ps
module kf_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kf_in_if                         in_i,
  kf_out_if                        out_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [kf_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]              pwdata_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);
  import kf_pkg::*;
  import kf_tb_pkg::*;

  localparam int unsigned SampleW = SampleBitsDef;
  localparam longint      Q16Max  = 64'sd2147483647;
  localparam longint      Q16Min  = -64'sd2147483648;

  logic        [31:0] proc_noise;
  logic        [31:0] meas_noise;
  logic        [31:0] cov_init;
  logic signed [31:0] est_acc;
  logic        [31:0] err_cov;

  kf_result_t want;
  kf_result_t expected_q[$];

  // One filter step or restart on the private copy of the state.
  function automatic kf_result_t kalman_update(input logic op,
                                               input logic signed [SampleW-1:0] smp);
    logic [63:0] pred;
    logic [63:0] mag;
    logic [63:0] corr;
    logic [31:0] gain;
    longint      target;
    longint      diff;
    longint      next_est;
    kf_result_t  res;
    if (op == OpRestart) begin
      est_acc = '0;
      err_cov = cov_init;
      res     = '0;
      return res;
    end
    pred = {32'd0, err_cov} + {32'd0, proc_noise};
    if (pred > 64'hFFFF_FFFF) begin
      pred = 64'hFFFF_FFFF;
    end
    if (pred == 64'd0) begin
      gain = '0;
    end else if (meas_noise == 32'd0) begin
      gain = '1;
    end else begin
      gain = 32'((pred << 32) / (pred + {32'd0, meas_noise}));
    end
    target = longint'(smp) * 65536;
    if (target > Q16Max) target = Q16Max;
    if (target < Q16Min) target = Q16Min;
    diff = target - longint'(est_acc);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    corr = (mag * {32'd0, gain}) >> 32;
    next_est = (diff < 0) ? longint'(est_acc) - longint'(corr)
                          : longint'(est_acc) + longint'(corr);
    est_acc = 32'(next_est);
    err_cov = 32'(((64'h1_0000_0000 - {32'd0, gain}) * pred) >> 32);
    res.estimate = est_acc[31:16];
    res.gain     = gain;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise   = ProcessNoiseRst;
      meas_noise   = MeasureNoiseRst;
      cov_init     = InitialCovRst;
      est_acc      = '0;
      err_cov      = InitialCovRst;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          RegProcessNoise: proc_noise = pwdata_i;
          RegMeasureNoise: meas_noise = pwdata_i;
          RegInitialCov:   cov_init   = pwdata_i;
          default: ;
        endcase
      end
      // Results are matched before new items are queued, so a result that
      // shows up with nothing outstanding is never paired with a fresh item.
      if (out_i.valid && out_i.ready) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $error("result with no item outstanding: estimate %0d, gain %0h",
                 out_i.estimate, out_i.gain);
        end else begin
          want = expected_q.pop_front();
          if (out_i.estimate !== want.estimate) begin
            fail_count_o++;
            $error("estimate mismatch: expected %0d, actual %0d",
                   want.estimate, out_i.estimate);
          end
          if (out_i.gain !== want.gain) begin
            fail_count_o++;
            $error("gain mismatch: expected %0h, actual %0h", want.gain, out_i.gain);
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        expected_q.push_back(kalman_update(in_i.op, in_i.sample));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb_top.sv
// Top of the filter testbench: clock, reset, stimulus, receiver and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import kf_pkg::*;
  import kf_tb_pkg::*;

  localparam int unsigned SampleW       = SampleBitsDef;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 120;
  localparam int unsigned BurstItems    = 24;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TailCycles    = 64;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              hold_rx;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_filter      = 0;
  int unsigned n_restart     = 0;
  int unsigned n_writes      = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  logic signed [SampleW-1:0] walk_level = '0;

  kf_in_if  in_if ();
  kf_out_if out_if ();

  scalar_kalman_filter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("scalar_kalman_filter regression: fail");
    $finish;
  end

  // Result receiver: random back-pressure, or a solid hold while hold_rx is set.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(input logic op, input logic signed [SampleW-1:0] smp);
    in_if.valid  <= 1'b1;
    in_if.op     <= op;
    in_if.sample <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    if (op == OpRestart) n_restart++;
    else n_filter++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drops valid and waits until every predicted result has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Setup and access cycle; psel stays high so writes can follow back to back.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    n_writes++;
  endtask

  task automatic program_regs(input logic [31:0] q, input logic [31:0] r,
                              input logic [31:0] c, input bit poke_unused);
    if (poke_unused) reg_write(RegUnused, $urandom);
    reg_write(RegProcessNoise, q);
    reg_write(RegMeasureNoise, r);
    reg_write(RegInitialCov, c);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_reg(input logic [31:0] dflt);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      3:       return 32'($urandom_range(32'hFFFF));
      4:       return $urandom;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // A slow random walk so the estimate has something to track, mixed in equal
  // share with full-range values, plus small values near zero and the extremes.
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return ($urandom_range(1) != 0) ? SampleMax : SampleMin;
      1:       return SampleW'($urandom_range(16)) - SampleW'(8);
      2, 3, 4, 5: begin
        walk_level = walk_level + SampleW'($urandom_range(64)) - SampleW'(32);
        return walk_level;
      end
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(24) == 0) ? OpRestart : OpFilter;
  endfunction

  initial begin
    rst_ni       <= 1'b0;
    hold_rx      <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OpFilter;
    in_if.sample <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default noise, sample extremes and a restart.
    push_item(OpFilter, SampleMax);
    push_item(OpFilter, SampleMin);
    push_item(OpFilter, SampleMax);
    push_item(OpFilter, '0);
    push_item(OpFilter, -16'sd1);
    push_item(OpRestart, SampleW'($urandom));
    push_item(OpFilter, 16'sd100);
    drain();

    // Saturating prediction with zero measurement noise: gain goes to all ones.
    program_regs('1, '0, InitialCovRst, 1'b0);
    push_item(OpFilter, 16'sd12345);
    push_item(OpFilter, SampleMin);
    drain();

    // Covariance and both noises zero: gain must be zero.
    program_regs('0, '0, '0, 1'b0);
    push_item(OpFilter, -16'sd5);
    push_item(OpFilter, 16'sd7);
    push_item(OpRestart, SampleMax);
    push_item(OpFilter, 16'sd9);
    drain();

    // A new initial covariance only shows after the next restart.
    program_regs('0, '1, '1, 1'b1);
    push_item(OpFilter, SampleMax);
    push_item(OpRestart, SampleMin);
    push_item(OpFilter, SampleMax);
    push_item(OpFilter, SampleMin);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        program_regs('1, '1, '1, 1'b0);
      end else begin
        program_regs(pick_reg(ProcessNoiseRst), pick_reg(MeasureNoiseRst),
                     pick_reg(InitialCovRst), 1'b0);
      end
      if (ph < 2) begin
        send_idle_pct  = 24;
        recv_idle_pct <= 86;
      end else if (ph < 4) begin
        send_idle_pct  = 86;
        recv_idle_pct <= 24;
      end else begin
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
      end
      push_item(OpRestart, SampleW'($urandom));
      if (ph == 4) begin
        // Receiver stalls for a long stretch while items keep coming.
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_rx <= 1'b0;
          end
          begin
            for (int unsigned i = 0; i < BurstItems; i++) push_item(OpFilter, pick_sample());
          end
        join
      end
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        push_item(pick_op(), pick_sample());
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d filter items and %0d restarts across %0d register writes.",
             n_filter, n_restart, n_writes);
    $display("%0d results compared under three back-pressure mixes and one long stall.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("scalar_kalman_filter regression: pass");
    end else begin
      $display("scalar_kalman_filter regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/kf_pkg.sv
rtl/kf_if.sv
rtl/scalar_kalman_filter.sv
rtl/kf_check.sv
tb/kf_tb_pkg.sv
tb/kf_checker.sv
tb/tb_top.sv
